// ===== rtl/tie_pkg.sv =====
// Package: operation codes, sizes and helper types for the execute unit.
`default_nettype none
package tie_pkg;
	localparam int GpRegs    = 16;
	localparam int DataDepth = 1024;
	localparam int CodeDepth = 1024;
	localparam int RegAw     = $clog2(GpRegs);
	localparam int MemAw     = $clog2(DataDepth);
	localparam int CodeAw    = $clog2(CodeDepth);

	typedef enum logic [4:0] {
		OP_NOP  = 5'd0,  OP_ADD  = 5'd1,  OP_ADDI = 5'd2,  OP_SUB  = 5'd3,
		OP_SUBI = 5'd4,  OP_MULT = 5'd5,  OP_DIVD = 5'd6,  OP_LD   = 5'd7,
		OP_LDI  = 5'd8,  OP_CMP  = 5'd9,  OP_STO  = 5'd10, OP_BLT  = 5'd11,
		OP_BGT  = 5'd12, OP_BEQ  = 5'd13, OP_HALT = 5'd14, OP_MOV  = 5'd15,
		OP_J    = 5'd16
	} op_t;

	localparam logic [1:0] FLAG_NONE = 2'd0;
	localparam logic [1:0] FLAG_LT   = 2'd1;
	localparam logic [1:0] FLAG_GT   = 2'd2;
	localparam logic [1:0] FLAG_EQ   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RDREG, ST_EXEC, ST_DIV, ST_MEMRD, ST_CLEAR, ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/tie_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tie_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/toy_isa_execute_writeback_top.sv =====
// Top level: execute and writeback unit of a small RISC machine.
`default_nettype none
// Usage:
// Input channel s_axis_* carries one decoded instruction per transaction;
// output channel m_axis_* returns one result transaction per instruction.
// State lives in two synchronous RAMs: a register file and a data memory.
// Three register-file copies let ra, rb and rd be read in the same cycle; every
// write goes to all three.
// Sequencing: one instruction at a time. Most operations pass through the
// accept, register read, execute and output states. ld adds a data memory
// read state; divd with a nonzero divisor adds the bit-serial restoring
// divider state. Halted items skip the read and execute.
// Reset: after arst_n rises the block sweeps the data memory and register
// file to zero, one entry per cycle, across all DataDepth (1024) addresses,
// while s_axis_tready stays low. Flags and the count reset at once.
// Stall: the result sits in an output register until m_axis_tready; no new
// instruction is accepted until it has been taken.
module toy_isa_execute_writeback_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: func[4:0], dest_or_target[14:5], src_a[46:15], src_b[78:47]
	input  wire  [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// tdata: write_enable[0], write_reg[4:1], write_value[36:5],
	// compare_result[38:37], branch_taken[39], branch_target[49:40],
	// halted[50], executed_total[82:51]
	output logic [87:0] m_axis_tdata
);
	import tie_pkg::*;

	state_t state_q, state_d;

	// Latched instruction.
	logic [4:0]  func_q;
	logic [9:0]  dt_q;
	logic [31:0] sa_q, sb_q;

	logic [1:0]  flag_q;
	logic        halt_q;
	logic [31:0] count_q;
	logic [MemAw:0] clr_q;

	// Operands after register read.
	logic [31:0] rb_q;
	// Divider.
	logic [31:0] quo_q, rem_q;
	logic [5:0]  dcnt_q;

	// Result register.
	logic        o_we_q, o_tk_q;
	logic [RegAw-1:0] o_reg_q;
	logic [31:0] o_val_q;
	logic [9:0]  o_tgt_q;

	logic [31:0] ra_r, rb_r, rd_r, mem_r;
	logic        rf_we, dm_we;
	logic [RegAw-1:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic [MemAw-1:0] dm_addr, dm_waddr;
	logic [31:0] dm_wdata;
	logic [31:0] addr_sum;
	logic        clearing;

	assign clearing = (state_q == ST_CLEAR);
	assign addr_sum = ra_r + sb_q;

	// Register file copies.
	tie_ram #(.Width(32), .Depth(GpRegs)) u_rf_a (.clk, .we(rf_we), .waddr(rf_waddr),
		.wdata(rf_wdata), .raddr(sa_q[RegAw-1:0]), .rdata(ra_r));
	tie_ram #(.Width(32), .Depth(GpRegs)) u_rf_b (.clk, .we(rf_we), .waddr(rf_waddr),
		.wdata(rf_wdata), .raddr(sb_q[RegAw-1:0]), .rdata(rb_r));
	tie_ram #(.Width(32), .Depth(GpRegs)) u_rf_d (.clk, .we(rf_we), .waddr(rf_waddr),
		.wdata(rf_wdata), .raddr(dt_q[RegAw-1:0]), .rdata(rd_r));
	tie_ram #(.Width(32), .Depth(DataDepth)) u_dm (.clk, .we(dm_we), .waddr(dm_waddr),
		.wdata(dm_wdata), .raddr(dm_addr), .rdata(mem_r));

	// Present the ld address in EXEC; the word arrives in MEMRD.
	assign dm_addr = addr_sum[MemAw-1:0];

	// Divider step.
	logic [32:0] dtrial;
	assign dtrial = {rem_q, quo_q[31]} - {1'b0, rb_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == (MemAw+1)'(DataDepth - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_d = halt_q ? ST_OUT : ST_RDREG;
			ST_RDREG: state_d = ST_EXEC;
			ST_EXEC: begin
				if (op_t'(func_q) == OP_DIVD && rb_r != '0) state_d = ST_DIV;
				else if (op_t'(func_q) == OP_LD) state_d = ST_MEMRD;
				else state_d = ST_OUT;
			end
			ST_DIV:   if (dcnt_q == 6'd31) state_d = ST_OUT;
			ST_MEMRD: state_d = ST_OUT;
			ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);

	// Writes: the clearing sweep, the sto store in EXEC, or the register commit when the result is taken.
	always_comb begin
		rf_we = 1'b0;
		rf_waddr = dt_q[RegAw-1:0];
		rf_wdata = o_val_q;
		dm_we = 1'b0;
		dm_waddr = addr_sum[MemAw-1:0];
		dm_wdata = rd_r;
		if (clearing) begin
			rf_we = 1'b1;
			rf_waddr = clr_q[RegAw-1:0];
			rf_wdata = '0;
			dm_we = 1'b1;
			dm_waddr = clr_q[MemAw-1:0];
			dm_wdata = '0;
		end else if (state_q == ST_EXEC) begin
			dm_we = (op_t'(func_q) == OP_STO);
		end else if (state_q == ST_OUT && state_d == ST_IDLE) begin
			rf_we = o_we_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			flag_q <= FLAG_NONE;
			halt_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (state_q == ST_EXEC) begin
				count_q <= count_q + 32'd1;
				if (op_t'(func_q) == OP_HALT) halt_q <= 1'b1;
				if (op_t'(func_q) == OP_CMP)
					flag_q <= (rd_r < ra_r) ? FLAG_LT : (rd_r > ra_r) ? FLAG_GT : FLAG_EQ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_q <= s_axis_tdata[4:0];
			dt_q   <= s_axis_tdata[14:5];
			sa_q   <= s_axis_tdata[46:15];
			sb_q   <= s_axis_tdata[78:47];
			o_we_q <= 1'b0;
			o_tk_q <= 1'b0;
			o_reg_q <= '0;
			o_val_q <= '0;
			o_tgt_q <= '0;
		end
		if (state_q == ST_EXEC) begin
			rb_q <= rb_r;
			quo_q <= ra_r;
			rem_q <= '0;
			dcnt_q <= '0;
			o_reg_q <= dt_q[RegAw-1:0];
			o_tgt_q <= 10'(dt_q[CodeAw-1:0]);
			case (op_t'(func_q))
				OP_ADD:  begin o_we_q <= 1'b1; o_val_q <= ra_r + rb_r; end
				OP_ADDI: begin o_we_q <= 1'b1; o_val_q <= ra_r + sb_q; end
				OP_SUB:  begin o_we_q <= 1'b1; o_val_q <= ra_r - rb_r; end
				OP_SUBI: begin o_we_q <= 1'b1; o_val_q <= ra_r - sb_q; end
				OP_MULT: begin o_we_q <= 1'b1; o_val_q <= ra_r * rb_r; end
				OP_DIVD: begin o_we_q <= 1'b1; o_val_q <= '1; end
				OP_LD:   o_we_q <= 1'b1;
				OP_LDI:  begin o_we_q <= 1'b1; o_val_q <= sa_q; end
				OP_MOV:  begin o_we_q <= 1'b1; o_val_q <= ra_r; end
				OP_BLT:  o_tk_q <= (flag_q == FLAG_LT);
				OP_BGT:  o_tk_q <= (flag_q == FLAG_GT);
				OP_BEQ:  o_tk_q <= (flag_q == FLAG_EQ);
				OP_J:    o_tk_q <= 1'b1;
				default: ;
			endcase
		end
		if (state_q == ST_DIV) begin
			// Restoring division: one quotient bit per cycle.
			dcnt_q <= dcnt_q + 6'd1;
			if (!dtrial[32]) begin
				rem_q <= dtrial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
				if (dcnt_q == 6'd31) o_val_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
				if (dcnt_q == 6'd31) o_val_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (state_q == ST_MEMRD) o_val_q <= mem_r;
	end

	assign m_axis_tdata = {5'd0, count_q, halt_q, o_tk_q ? o_tgt_q : 10'd0, o_tk_q,
		flag_q, o_we_q ? o_val_q : 32'd0, o_we_q ? 4'(o_reg_q) : 4'd0, o_we_q};

`ifndef SYNTHESIS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready) else $error("accept during clear");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> halt_q) else $error("halt cleared");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC) |=> $stable(count_q)) else $error("count moved");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/toy_isa_execute_writeback_top_tb.sv =====
// Testbench: random and directed instruction streams checked against an inline execute model.
`timescale 1ns / 100ps
`default_nettype none
module toy_isa_execute_writeback_top_tb;
	import tie_pkg::*;

	typedef struct packed {
		logic [31:0] src_b;
		logic [31:0] src_a;
		logic [9:0]  dest_or_target;
		logic [4:0]  func;
	} instr_t;

	typedef struct packed {
		logic [31:0] executed_total;
		logic        halted;
		logic [9:0]  branch_target;
		logic        branch_taken;
		logic [1:0]  compare_result;
		logic [31:0] write_value;
		logic [3:0]  write_reg;
		logic        write_enable;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// tdata: func, dest_or_target, src_a, src_b (lowest first)
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// tdata: write_enable, write_reg, write_value, compare_result, branch_taken,
	// branch_target, halted, executed_total (lowest first)
	logic [87:0] m_axis_tdata;

	toy_isa_execute_writeback_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow machine state
	logic [31:0] shadow_regs [GpRegs];
	logic [31:0] shadow_mem [DataDepth];
	logic [1:0]  shadow_flag;
	logic        shadow_halt;
	logic [31:0] shadow_count;

	instr_t   pending_instrs[$];
	outcome_t expected_outcomes[$];
	int       errors = 0;
	int       results_seen = 0;
	bit       stim_done = 0;
	bit       calm = 0;  // no idling in the final stretch
	int       src_idle = 0;
	int       sink_idle = 0;
	int       halts_seen = 0;

	// Execute one instruction on the shadow state and return the outcome.
	function automatic outcome_t execute_instr(instr_t it);
		outcome_t   o;
		logic [3:0] rd;
		logic [31:0] ra, rb, wval;
		logic [MemAw-1:0] addr;
		logic wen, taken;
		o = '0;
		rd = it.dest_or_target[3:0];
		ra = shadow_regs[it.src_a[3:0]];
		rb = shadow_regs[it.src_b[3:0]];
		addr = MemAw'(ra + it.src_b);
		wen = 0; wval = 0; taken = 0;
		if (!shadow_halt) begin
			case (it.func)
				OP_ADD:  begin wen = 1; wval = ra + rb; end
				OP_ADDI: begin wen = 1; wval = ra + it.src_b; end
				OP_SUB:  begin wen = 1; wval = ra - rb; end
				OP_SUBI: begin wen = 1; wval = ra - it.src_b; end
				OP_MULT: begin wen = 1; wval = ra * rb; end
				OP_DIVD: begin wen = 1; wval = (rb != 0) ? ra / rb : '1; end
				OP_LD:   begin wen = 1; wval = shadow_mem[addr]; end
				OP_LDI:  begin wen = 1; wval = it.src_a; end
				OP_MOV:  begin wen = 1; wval = ra; end
				OP_STO:  shadow_mem[addr] = shadow_regs[rd];
				OP_CMP: begin
					if (shadow_regs[rd] < ra) shadow_flag = FLAG_LT;
					else if (shadow_regs[rd] > ra) shadow_flag = FLAG_GT;
					else shadow_flag = FLAG_EQ;
				end
				OP_BLT:  taken = (shadow_flag == FLAG_LT);
				OP_BGT:  taken = (shadow_flag == FLAG_GT);
				OP_BEQ:  taken = (shadow_flag == FLAG_EQ);
				OP_J:    taken = 1;
				OP_HALT: shadow_halt = 1;
				default: ;
			endcase
			if (wen) shadow_regs[rd] = wval;
			shadow_count = shadow_count + 1;
		end
		o.write_enable   = wen;
		o.write_reg      = wen ? rd : 4'd0;
		o.write_value    = wen ? wval : 32'd0;
		o.compare_result = shadow_flag;
		o.branch_taken   = taken;
		o.branch_target  = taken ? it.dest_or_target : 10'd0;
		o.halted         = shadow_halt;
		o.executed_total = shadow_count;
		return o;
	endfunction

	function automatic instr_t make_instr(logic [4:0] f, logic [9:0] d,
			logic [31:0] a, logic [31:0] b);
		instr_t it;
		it.func = f; it.dest_or_target = d; it.src_a = a; it.src_b = b;
		return it;
	endfunction

	// Random instruction; register indices mostly small, high bits now and then.
	function automatic instr_t rand_instr(bit allow_halt);
		instr_t it;
		int f;
		f = $urandom_range(0, 31);
		if (f > 16 && $urandom_range(0, 3) != 0) f = $urandom_range(0, 16);
		if (f == OP_HALT && !allow_halt) f = OP_ADD;
		it.func = 5'(f);
		it.dest_or_target = 10'($urandom);
		it.src_a = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
		it.src_b = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
		if (f == OP_LDI || $urandom_range(0, 7) == 0) it.src_a = $urandom;
		if (f == OP_ADDI || f == OP_SUBI) it.src_b = $urandom;
		return it;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// Fill the instruction queue: directed corner cases first, then random programs.
	initial begin
		logic [9:0] d;
		// Shadow state starts from the reset values.
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		foreach (shadow_mem[i]) shadow_mem[i] = '0;
		shadow_flag  = FLAG_NONE;
		shadow_halt  = 1'b0;
		shadow_count = '0;
		pending_instrs.push_back(make_instr(OP_BLT, 10'd5, 0, 0));   // no compare yet
		pending_instrs.push_back(make_instr(OP_LDI, 10'd1, '1, 0));
		pending_instrs.push_back(make_instr(OP_LDI, 10'h3F2, 32'h8000_0001, 0)); // r2 via wrap
		pending_instrs.push_back(make_instr(OP_ADD, 10'd3, 1, 2));
		pending_instrs.push_back(make_instr(OP_ADDI, 10'd4, 1, '1));
		pending_instrs.push_back(make_instr(OP_SUB, 10'd5, 2, 1));
		pending_instrs.push_back(make_instr(OP_SUBI, 10'd6, 0, 1));
		pending_instrs.push_back(make_instr(OP_MULT, 10'd7, 1, 1));
		pending_instrs.push_back(make_instr(OP_DIVD, 10'd8, 1, 2));
		pending_instrs.push_back(make_instr(OP_DIVD, 10'd9, 1, 0));  // divide by zero
		pending_instrs.push_back(make_instr(OP_STO, 10'd1, 1, '1));  // address wraps
		pending_instrs.push_back(make_instr(OP_LD, 10'd10, 1, '1));
		pending_instrs.push_back(make_instr(OP_LD, 10'd11, 0, 1023));
		pending_instrs.push_back(make_instr(OP_MOV, 10'd15, 32'hFFFF_FFF2, 0));
		pending_instrs.push_back(make_instr(OP_CMP, 10'd0, 1, 0));
		pending_instrs.push_back(make_instr(OP_BLT, 10'h3FF, 0, 0));
		pending_instrs.push_back(make_instr(OP_CMP, 10'd1, 0, 0));
		pending_instrs.push_back(make_instr(OP_BGT, 10'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_CMP, 10'd1, 1, 0));
		pending_instrs.push_back(make_instr(OP_BEQ, 10'h2AA, 0, 0));
		pending_instrs.push_back(make_instr(OP_BLT, 10'h155, 0, 0));
		pending_instrs.push_back(make_instr(OP_J, 10'h3FF, '1, '1));
		pending_instrs.push_back(make_instr(5'd31, 10'h3FF, '1, '1)); // unknown code
		pending_instrs.push_back(make_instr(5'd17, 10'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_NOP, 10'd0, 0, 0));
		for (int i = 0; i < 640; i++) begin
			// Seed a register with a full-range value now and then so compares vary.
			if ($urandom_range(0, 9) == 0) begin
				d = 10'($urandom);
				pending_instrs.push_back(make_instr(OP_LDI, d, $urandom, $urandom));
			end else
				pending_instrs.push_back(rand_instr(0));
		end
		// Halt, then items that must be ignored.
		pending_instrs.push_back(make_instr(OP_HALT, 10'd0, 0, 0));
		for (int i = 0; i < 10; i++)
			pending_instrs.push_back(rand_instr(1));
	end

	// Driver: present queued instructions, idle in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata  <= '0;
			src_idle      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_outcomes.push_back(execute_instr(instr_t'(s_axis_tdata[78:0])));
				if (pending_instrs.size() < 60) calm <= 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_idle > 0) begin
					src_idle <= src_idle - 1;
					s_axis_tvalid <= 0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					src_idle <= $urandom_range(1, 9) - 1;
					s_axis_tvalid <= 0;
				end else if (pending_instrs.size() > 0) begin
					s_axis_tdata  <= {1'b0, pending_instrs.pop_front()};
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
					stim_done <= 1;
				end
			end
		end
	end

	// Monitor: stall in random bursts, compare each result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 0;
			sink_idle     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = outcome_t'(m_axis_tdata[82:0]);
				results_seen <= results_seen + 1;
				if (got.halted) halts_seen <= halts_seen + 1;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_outcomes.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
			if (sink_idle > 0) begin
				sink_idle <= sink_idle - 1;
				m_axis_tready <= 0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				sink_idle <= $urandom_range(1, 9) - 1;
				m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	// Finish once every instruction has been answered.
	initial begin
		wait (stim_done);
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d instructions through all opcodes, corner cases and random programs;",
			results_seen);
		$display("%0d results reported the halted state.", halts_seen);
		if (errors == 0)
			$display("[toy_isa_execute_writeback_top] OK");
		else
			$display("[toy_isa_execute_writeback_top] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[toy_isa_execute_writeback_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/tie_pkg.sv
rtl/tie_ram.sv
rtl/toy_isa_execute_writeback_top.sv
tb/sv/toy_isa_execute_writeback_top_tb.sv
